// ===== hdl/gpx_pkg.sv =====
package gpx_pkg;

  // Fixed widths of the bus and pin fields
  localparam int AddrW  = 7;
  localparam int ByteW  = 8;
  localparam int PtrW   = 3;
  localparam int PinIdxW = 4;
  localparam int PinsW  = 16;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;

  localparam logic [AddrW-1:0] DevAddrReset = 7'h74;
  localparam logic [ByteW-1:0] ByteOnes     = 8'hff;
  localparam logic [ByteW-1:0] ByteZero     = 8'h00;

  // Event kinds
  typedef enum logic [1:0] {
    OP_BUS_WR   = 2'd0,
    OP_BUS_RD   = 2'd1,
    OP_PIN      = 2'd2,
    OP_RST_LINE = 2'd3
  } op_t;

  // Register groups, selected by pointer bits [2:1]
  typedef enum logic [1:0] {
    GRP_INPUT     = 2'd0,
    GRP_OUTPUT    = 2'd1,
    GRP_POLARITY  = 2'd2,
    GRP_DIRECTION = 2'd3
  } grp_t;

  // Register index of the configuration port
  localparam logic REG_DEV_ADDR = 1'b0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [AddrW-1:0]   bus_address;
    logic [ByteW-1:0]   write_byte;
    logic               restart;
    logic               stop;
    logic [PinIdxW-1:0] pin_index;
    logic               line_level;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] read_byte;
    logic [PinsW-1:0] pin_values;
    logic [PinsW-1:0] pin_drive_enable;
    logic             irq_n;
  } result_t;

  // Physical level of one bank: inputs show the external level, outputs the latch
  function automatic logic [ByteW-1:0] port_level(input logic [ByteW-1:0] ext,
                                                  input logic [ByteW-1:0] dir,
                                                  input logic [ByteW-1:0] latch);
    port_level = (ext & dir) | (latch & ~dir);
  endfunction

endpackage

// ===== hdl/gpx_in_if.sv =====
interface gpx_in_if;
  logic            valid;
  logic            ready;
  gpx_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gpx_out_if.sv =====
interface gpx_out_if;
  logic             valid;
  logic             ready;
  gpx_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gpx_cfg.sv =====
module gpx_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gpx_pkg::CfgAddrW-1:0]     paddr,
  input  logic [gpx_pkg::CfgDataW-1:0]     pwdata,
  output logic [gpx_pkg::CfgDataW-1:0]     prdata,
  output logic [gpx_pkg::AddrW-1:0]        dev_addr
);

  logic [gpx_pkg::AddrW-1:0] dev_addr_r;
  logic [gpx_pkg::AddrW-1:0] dev_addr_nxt;
  logic                      hit;

  // Decode the single word register
  assign hit = (paddr[gpx_pkg::CfgAddrW-1] == gpx_pkg::REG_DEV_ADDR);

  // Take the write at the access phase
  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (psel && penable && pwrite && hit) begin
      dev_addr_nxt = pwdata[gpx_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= gpx_pkg::DevAddrReset;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  // Read back
  assign prdata = hit ? {{(gpx_pkg::CfgDataW-gpx_pkg::AddrW){1'b0}}, dev_addr_r}
                      : '0;
  assign dev_addr = dev_addr_r;

endmodule

// ===== hdl/gpx_core.sv =====
module gpx_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  gpx_pkg::item_t            item,
  input  logic [gpx_pkg::AddrW-1:0] dev_addr,
  output gpx_pkg::result_t          res
);

  localparam int BW = gpx_pkg::ByteW;

  logic [1:0][BW-1:0] latch_r, latch_nxt;
  logic [1:0][BW-1:0] pol_r, pol_nxt;
  logic [1:0][BW-1:0] dir_r, dir_nxt;
  logic [1:0][BW-1:0] snap_r, snap_nxt;
  logic [gpx_pkg::PinsW-1:0] ext_r, ext_nxt;
  logic [gpx_pkg::PtrW-1:0]  ptr_r, ptr_nxt;
  logic open_r, open_nxt;
  logic exp_r, exp_nxt;
  logic held_r, held_nxt;
  logic irq_r, irq_nxt;

  logic [1:0][BW-1:0] port_cur, port_new;
  logic               bank;
  logic               bus_op;
  logic               bus_err;
  logic               exp_v;
  logic               irq_eval;
  logic               irq_set;
  logic               snap_all;
  logic               snap_rd;
  logic               pending;
  logic               status;
  logic [BW-1:0]      rbyte;

  assign bank    = ptr_r[0];
  assign bus_op  = (item.opcode == gpx_pkg::OP_BUS_WR) || (item.opcode == gpx_pkg::OP_BUS_RD);
  assign bus_err = (item.bus_address != dev_addr) || held_r;

  // Port levels from the current registers
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      port_cur[b] = gpx_pkg::port_level(ext_r[b*BW +: BW], dir_r[b], latch_r[b]);
    end
  end

  // Register updates for one event
  always_comb begin
    latch_nxt = latch_r;
    pol_nxt   = pol_r;
    dir_nxt   = dir_r;
    ext_nxt   = ext_r;
    ptr_nxt   = ptr_r;
    open_nxt  = open_r;
    exp_nxt   = exp_r;
    held_nxt  = held_r;
    exp_v     = exp_r;
    irq_eval  = 1'b0;
    irq_set   = 1'b0;
    snap_all  = 1'b0;
    snap_rd   = 1'b0;
    status    = 1'b0;
    rbyte     = '0;
    case (item.opcode)
      gpx_pkg::OP_BUS_WR, gpx_pkg::OP_BUS_RD: begin
        if (bus_err) begin
          status = 1'b1;
        end else begin
          if ((!open_r || item.restart) && (item.opcode == gpx_pkg::OP_BUS_WR)) begin
            exp_v = 1'b1;
          end
          if (item.opcode == gpx_pkg::OP_BUS_WR) begin
            if (exp_v) begin
              ptr_nxt = item.write_byte[gpx_pkg::PtrW-1:0];
              exp_v   = 1'b0;
            end else begin
              case (ptr_r[2:1])
                gpx_pkg::GRP_OUTPUT:    latch_nxt[bank] = item.write_byte;
                gpx_pkg::GRP_POLARITY:  pol_nxt[bank]   = item.write_byte;
                gpx_pkg::GRP_DIRECTION: begin
                  dir_nxt[bank] = item.write_byte;
                  irq_eval      = 1'b1;
                end
                default: ;
              endcase
              ptr_nxt = ptr_r ^ gpx_pkg::PtrW'(1);
            end
          end else begin
            case (ptr_r[2:1])
              gpx_pkg::GRP_INPUT: begin
                rbyte    = port_cur[bank] ^ (pol_r[bank] & dir_r[bank]);
                snap_rd  = 1'b1;
                irq_eval = 1'b1;
              end
              gpx_pkg::GRP_OUTPUT:   rbyte = latch_r[bank];
              gpx_pkg::GRP_POLARITY: rbyte = pol_r[bank];
              default:               rbyte = dir_r[bank];
            endcase
            ptr_nxt = ptr_r ^ gpx_pkg::PtrW'(1);
          end
          // Close the transfer on stop
          if (item.stop) begin
            open_nxt = 1'b0;
            exp_v    = 1'b1;
          end else begin
            open_nxt = 1'b1;
          end
          exp_nxt = exp_v;
        end
      end
      gpx_pkg::OP_PIN: begin
        if (ext_r[item.pin_index] != item.line_level) begin
          ext_nxt[item.pin_index] = item.line_level;
          if (held_r) begin
            snap_all = 1'b1;
          end else begin
            irq_eval = 1'b1;
          end
        end
      end
      default: begin
        if (!item.line_level) begin
          held_nxt  = 1'b1;
          latch_nxt = {2{gpx_pkg::ByteOnes}};
          pol_nxt   = {2{gpx_pkg::ByteZero}};
          dir_nxt   = {2{gpx_pkg::ByteOnes}};
          ptr_nxt   = '0;
          open_nxt  = 1'b0;
          exp_nxt   = 1'b1;
          snap_all  = 1'b1;
          irq_set   = 1'b1;
        end else if (held_r) begin
          held_nxt = 1'b0;
          snap_all = 1'b1;
          irq_set  = 1'b1;
        end
      end
    endcase
  end

  // Snapshot and interrupt from the updated registers
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      port_new[b] = gpx_pkg::port_level(ext_nxt[b*BW +: BW], dir_nxt[b], latch_nxt[b]);
    end
    snap_nxt = snap_r;
    if (snap_all) begin
      snap_nxt = port_new;
    end else if (snap_rd) begin
      snap_nxt[bank] = port_new[bank];
    end
    pending = (|((port_new[0] ^ snap_nxt[0]) & dir_nxt[0])) ||
              (|((port_new[1] ^ snap_nxt[1]) & dir_nxt[1]));
    if (irq_set) begin
      irq_nxt = 1'b1;
    end else if (irq_eval) begin
      irq_nxt = !pending;
    end else begin
      irq_nxt = irq_r;
    end
  end

  // Result of this event
  always_comb begin
    res.status           = status;
    res.read_byte        = rbyte;
    res.pin_values       = {port_new[1], port_new[0]};
    res.pin_drive_enable = ~{dir_nxt[1], dir_nxt[0]};
    res.irq_n            = irq_nxt;
  end

  // Commit state when the event advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= {2{gpx_pkg::ByteOnes}};
      pol_r   <= {2{gpx_pkg::ByteZero}};
      dir_r   <= {2{gpx_pkg::ByteOnes}};
      snap_r  <= {2{gpx_pkg::ByteZero}};
      ext_r   <= '0;
      ptr_r   <= '0;
      open_r  <= 1'b0;
      exp_r   <= 1'b1;
      held_r  <= 1'b0;
      irq_r   <= 1'b1;
    end else if (step) begin
      latch_r <= latch_nxt;
      pol_r   <= pol_nxt;
      dir_r   <= dir_nxt;
      snap_r  <= snap_nxt;
      ext_r   <= ext_nxt;
      ptr_r   <= ptr_nxt;
      open_r  <= open_nxt;
      exp_r   <= exp_nxt;
      held_r  <= held_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // Reset line low restores the defaults and raises the interrupt line
  a_rst_line: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.opcode == gpx_pkg::OP_RST_LINE && !item.line_level
    |=> held_r && irq_r && ptr_r == '0 && !open_r && exp_r)
    else $error("reset line low did not restore defaults");

  // Interrupt never pending while reset is held
  a_irq_held: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> irq_r)
    else $error("interrupt pending while reset held");

  // Refused bus byte leaves the bus state alone
  a_bus_err: assert property (@(posedge clk) disable iff (!rst_n)
    step && bus_op && bus_err
    |=> $stable(ptr_r) && $stable(open_r) && $stable(latch_r) && $stable(dir_r))
    else $error("refused bus byte changed state");

  // Stop closes the transfer
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    step && bus_op && !bus_err && item.stop |=> !open_r && exp_r)
    else $error("stop did not close transfer");

endmodule

// ===== hdl/i2c_sixteen_bit_gpio_expander_unit.sv =====
// Channel  | Dir | Handshake            | Payload
// in_ch    | in  | valid/ready          | opcode, bus_address, write_byte, restart, stop,
//          |     |                      | pin_index, line_level
// out_ch   | out | valid/ready          | status, read_byte, pin_values, pin_drive_enable, irq_n
// cfg_*    | in  | APB write at access  | device_address at byte address 0
//
// One event per cycle sustained while the result channel is not stalled; an accepted event
// goes through the input register, then one pass through the register logic, into the result register.
// rst_n is synchronous: the state and valid registers take their defaults (the input and result data
// registers are not reset), pins read low, irq_n high. A stalled result holds in the output register
// while the input register still takes one more event; the core advances only when the output register frees up.
module i2c_sixteen_bit_gpio_expander_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  gpx_in_if.sink                        in_ch,
  gpx_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gpx_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [gpx_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [gpx_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  gpx_pkg::item_t            inq_r, inq_nxt;
  logic                      inq_vld_r, inq_vld_nxt;
  gpx_pkg::result_t          res_r, res_nxt;
  logic                      out_vld_r, out_vld_nxt;
  gpx_pkg::result_t          core_res;
  logic [gpx_pkg::AddrW-1:0] dev_addr;
  logic                      advance;
  logic                      in_take;

  gpx_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .dev_addr (dev_addr)
  );
  assign cfg_pready = 1'b1;

  gpx_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (inq_r),
    .dev_addr (dev_addr),
    .res      (core_res)
  );

  // Advance when the output register is free or being drained
  assign advance     = inq_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !inq_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input and output register next values
  always_comb begin
    inq_nxt     = inq_r;
    inq_vld_nxt = inq_vld_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (in_take) begin
      inq_nxt     = in_ch.data;
      inq_vld_nxt = 1'b1;
    end else if (advance) begin
      inq_vld_nxt = 1'b0;
    end
    if (advance) begin
      res_nxt     = core_res;
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      inq_vld_r <= inq_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inq_r <= inq_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = res_r;

  // Core steps only with a held event and room downstream
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> inq_vld_r && (!out_vld_r || out_ch.ready))
    else $error("core stepped without room");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(res_r))
    else $error("stalled result changed");

  // An advance always lands a result
  a_land: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("advanced event produced no result");

endmodule

// ===== tb/sv/i2c_sixteen_bit_gpio_expander_unit_tb.sv =====
module i2c_sixteen_bit_gpio_expander_unit_tb;

  localparam int PhaseEvents = 350;
  localparam int QuietLimit  = 3000;
  localparam int HoldCycles  = 150;
  localparam int ItemW       = $bits(gpx_pkg::item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [gpx_pkg::CfgAddrW-1:0] cfg_paddr   = '0;
  logic [gpx_pkg::CfgDataW-1:0] cfg_pwdata  = '0;
  logic [gpx_pkg::CfgDataW-1:0] cfg_prdata;
  logic                         cfg_pready;

  gpx_in_if  in_ch ();
  gpx_out_if out_ch ();

  i2c_sixteen_bit_gpio_expander_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial forever #1 clk = ~clk;

  // Expander state as the testbench tracks it
  logic [gpx_pkg::AddrW-1:0] dev_addr;
  logic [gpx_pkg::ByteW-1:0] out_latch [2];
  logic [gpx_pkg::ByteW-1:0] pol_mask [2];
  logic [gpx_pkg::ByteW-1:0] dir_mask [2];
  logic [gpx_pkg::ByteW-1:0] in_snap [2];
  logic [gpx_pkg::PtrW-1:0]  reg_ptr;
  logic                      xfer_open;
  logic                      ptr_next;
  logic [gpx_pkg::PinsW-1:0] pin_ext;
  logic                      chip_held;
  logic                      irq_line;

  gpx_pkg::item_t   events_pending [$];
  gpx_pkg::result_t results_due [$];

  int n_sent, n_checked, n_bad, n_addrs;

  // Level seen on one bank: inputs follow the pins, outputs follow the latch
  function automatic logic [gpx_pkg::ByteW-1:0] bank_level(int b);
    return (pin_ext[gpx_pkg::ByteW*b +: gpx_pkg::ByteW] & dir_mask[b]) |
           (out_latch[b] & ~dir_mask[b]);
  endfunction

  function automatic void latch_snapshot();
    in_snap[0] = bank_level(0);
    in_snap[1] = bank_level(1);
  endfunction

  // Pull the interrupt low while any input pin differs from its snapshot
  function automatic void recompute_irq();
    logic pend;
    pend = 1'b0;
    for (int b = 0; b < 2; b++)
      if (((bank_level(b) ^ in_snap[b]) & dir_mask[b]) != '0) pend = 1'b1;
    irq_line = ~pend;
  endfunction

  function automatic void restore_defaults();
    for (int b = 0; b < 2; b++) begin
      out_latch[b] = gpx_pkg::ByteOnes;
      pol_mask[b]  = gpx_pkg::ByteZero;
      dir_mask[b]  = gpx_pkg::ByteOnes;
    end
    reg_ptr   = '0;
    xfer_open = 1'b0;
    ptr_next  = 1'b1;
    latch_snapshot();
    irq_line = 1'b1;
  endfunction

  function automatic logic [gpx_pkg::ByteW-1:0] fetch_pointed_reg();
    int b;
    logic [gpx_pkg::ByteW-1:0] lvl;
    b = reg_ptr[0];
    case (gpx_pkg::grp_t'(reg_ptr[2:1]))
      gpx_pkg::GRP_INPUT: begin
        lvl = bank_level(b);
        in_snap[b] = lvl;
        recompute_irq();
        return lvl ^ (pol_mask[b] & dir_mask[b]);
      end
      gpx_pkg::GRP_OUTPUT:   return out_latch[b];
      gpx_pkg::GRP_POLARITY: return pol_mask[b];
      default:               return dir_mask[b];
    endcase
  endfunction

  function automatic void store_pointed_reg(logic [gpx_pkg::ByteW-1:0] d);
    int b;
    b = reg_ptr[0];
    case (gpx_pkg::grp_t'(reg_ptr[2:1]))
      gpx_pkg::GRP_OUTPUT:   out_latch[b] = d;
      gpx_pkg::GRP_POLARITY: pol_mask[b] = d;
      gpx_pkg::GRP_DIRECTION: begin
        dir_mask[b] = d;
        recompute_irq();
      end
      default: ;
    endcase
  endfunction

  // Apply one event to the tracked state and form the result it causes
  function automatic gpx_pkg::result_t expander_step(gpx_pkg::item_t ev);
    gpx_pkg::result_t r;
    gpx_pkg::op_t op;
    r = '0;
    op = gpx_pkg::op_t'(ev.opcode);
    case (op)
      gpx_pkg::OP_BUS_WR, gpx_pkg::OP_BUS_RD: begin
        if (ev.bus_address != dev_addr || chip_held) begin
          r.status = 1'b1;
        end else begin
          if (!xfer_open || ev.restart) begin
            xfer_open = 1'b1;
            if (op == gpx_pkg::OP_BUS_WR) ptr_next = 1'b1;
          end
          if (op == gpx_pkg::OP_BUS_WR) begin
            if (ptr_next) begin
              reg_ptr = ev.write_byte[gpx_pkg::PtrW-1:0];
              ptr_next = 1'b0;
            end else begin
              store_pointed_reg(ev.write_byte);
              reg_ptr[0] = ~reg_ptr[0];
            end
          end else begin
            r.read_byte = fetch_pointed_reg();
            reg_ptr[0] = ~reg_ptr[0];
          end
          if (ev.stop) begin
            xfer_open = 1'b0;
            ptr_next = 1'b1;
          end
        end
      end
      gpx_pkg::OP_PIN: begin
        if (pin_ext[ev.pin_index] != ev.line_level) begin
          pin_ext[ev.pin_index] = ev.line_level;
          if (chip_held) latch_snapshot();
          else recompute_irq();
        end
      end
      default: begin
        if (!ev.line_level) begin
          chip_held = 1'b1;
          restore_defaults();
        end else if (chip_held) begin
          chip_held = 1'b0;
          latch_snapshot();
          recompute_irq();
        end
      end
    endcase
    r.pin_values       = {bank_level(1), bank_level(0)};
    r.pin_drive_enable = {~dir_mask[1], ~dir_mask[0]};
    r.irq_n            = irq_line;
    return r;
  endfunction

  // Gap length: mostly none or short, a few long, with calm stretches of none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Stimulus helpers: fields an event does not use stay random
  function automatic gpx_pkg::item_t noise_item();
    logic [ItemW-1:0] raw;
    raw = ItemW'($urandom);
    return raw;
  endfunction

  function automatic logic [gpx_pkg::ByteW-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return gpx_pkg::ByteZero;
    if (r < 30) return gpx_pkg::ByteOnes;
    return gpx_pkg::ByteW'($urandom);
  endfunction

  function automatic logic [gpx_pkg::AddrW-1:0] bus_target();
    if ($urandom_range(0, 9) == 0) return gpx_pkg::AddrW'($urandom);
    return dev_addr;
  endfunction

  function automatic void queue_bus(gpx_pkg::op_t op, logic [gpx_pkg::AddrW-1:0] a,
                                    logic [gpx_pkg::ByteW-1:0] d, logic rs, logic sp);
    gpx_pkg::item_t it;
    it = noise_item();
    it.opcode      = op;
    it.bus_address = a;
    it.write_byte  = d;
    it.restart     = rs;
    it.stop        = sp;
    events_pending.push_back(it);
  endfunction

  function automatic void queue_pin(logic [gpx_pkg::PinIdxW-1:0] idx, logic lvl);
    gpx_pkg::item_t it;
    it = noise_item();
    it.opcode     = gpx_pkg::OP_PIN;
    it.pin_index  = idx;
    it.line_level = lvl;
    events_pending.push_back(it);
  endfunction

  function automatic void queue_reset_line(logic lvl);
    gpx_pkg::item_t it;
    it = noise_item();
    it.opcode     = gpx_pkg::OP_RST_LINE;
    it.line_level = lvl;
    events_pending.push_back(it);
  endfunction

  // Short hand-picked sequence over every event kind and corner
  function automatic void queue_directed();
    logic [gpx_pkg::AddrW-1:0] a;
    a = dev_addr;
    // output latches: bank 0 all low, bank 1 pattern
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h02, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h00, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'ha5, 1'b0, 1'b1);
    // direction: bank 0 all outputs, bank 1 upper nibble inputs
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h06, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h00, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'hf0, 1'b0, 1'b1);
    // input pins rise, same level again, then an output pin
    queue_pin(4'd15, 1'b1);
    queue_pin(4'd12, 1'b1);
    queue_pin(4'd12, 1'b1);
    queue_pin(4'd3, 1'b1);
    // polarity: bank 1 inverted
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h04, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h00, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'hff, 1'b0, 1'b1);
    // read both input banks after a repeated start
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h01, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_RD, a, 8'h00, 1'b1, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_RD, a, 8'hff, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_RD, a, 8'h00, 1'b0, 1'b1);
    // write into an input register: dropped, pointer still toggles
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'hf8, 1'b0, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h55, 1'b0, 1'b1);
    // wrong address (every address bit inverted) on a write and on a read
    queue_bus(gpx_pkg::OP_BUS_WR, ~a, 8'h06, 1'b1, 1'b0);
    queue_bus(gpx_pkg::OP_BUS_RD, a ^ 7'h7f, 8'h00, 1'b0, 1'b1);
    // reset line: held, pin and bus while held, held again, released twice
    queue_reset_line(1'b0);
    queue_pin(4'd13, 1'b1);
    queue_bus(gpx_pkg::OP_BUS_WR, a, 8'h02, 1'b1, 1'b1);
    queue_reset_line(1'b0);
    queue_reset_line(1'b1);
    queue_reset_line(1'b1);
  endfunction

  // One random burst: mostly well-formed transfers, some pins, resets and noise
  function automatic void queue_random_activity();
    int kind, n;
    gpx_pkg::item_t it;
    kind = $urandom_range(0, 99);
    n = $urandom_range(1, 4);
    if (kind < 35) begin
      queue_bus(gpx_pkg::OP_BUS_WR, bus_target(), gpx_pkg::ByteW'($urandom),
                $urandom_range(0, 3) == 0, 1'b0);
      for (int i = 0; i < n; i++)
        queue_bus(gpx_pkg::OP_BUS_WR, bus_target(), rand_byte(), 1'b0,
                  i == n - 1 && $urandom_range(0, 9) != 0);
    end else if (kind < 58) begin
      queue_bus(gpx_pkg::OP_BUS_WR, bus_target(), gpx_pkg::ByteW'($urandom),
                $urandom_range(0, 3) == 0, 1'b0);
      for (int i = 0; i < n; i++)
        queue_bus(gpx_pkg::OP_BUS_RD, bus_target(), gpx_pkg::ByteW'($urandom),
                  i == 0, i == n - 1);
    end else if (kind < 63) begin
      queue_bus(gpx_pkg::OP_BUS_RD, bus_target(), gpx_pkg::ByteW'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (kind < 88) begin
      repeat (n) queue_pin(gpx_pkg::PinIdxW'($urandom), 1'($urandom_range(0, 1)));
    end else if (kind < 92) begin
      queue_reset_line(1'b0);
      if ($urandom_range(0, 1)) queue_reset_line(1'b0);
      repeat (n) begin
        if ($urandom_range(0, 1))
          queue_pin(gpx_pkg::PinIdxW'($urandom), 1'($urandom_range(0, 1)));
        else
          queue_bus(gpx_pkg::op_t'($urandom_range(0, 1)), bus_target(), rand_byte(),
                    1'b0, 1'b0);
      end
      queue_reset_line(1'b1);
    end else begin
      it = noise_item();
      if (it.opcode == gpx_pkg::OP_RST_LINE) it.line_level = 1'b1;
      events_pending.push_back(it);
    end
  endfunction

  // Compare one transfer on the result channel with the oldest expectation
  function automatic void check_result(gpx_pkg::result_t got);
    gpx_pkg::result_t want;
    if (results_due.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("unexpected result with none pending: %p", got);
      return;
    end
    want = results_due.pop_front();
    n_checked++;
    if (got.status !== want.status || got.read_byte !== want.read_byte ||
        got.pin_values !== want.pin_values || got.pin_drive_enable !== want.pin_drive_enable ||
        got.irq_n !== want.irq_n) begin
      n_bad++;
      if (n_bad <= 10)
        $display("result %0d mismatch (exp/got): status %0b/%0b rd %02h/%02h pins %04h/%04h %s",
                 n_checked, want.status, got.status, want.read_byte, got.read_byte,
                 want.pin_values, got.pin_values,
                 $sformatf("drv %04h/%04h irq_n %0b/%0b", want.pin_drive_enable,
                           got.pin_drive_enable, want.irq_n, got.irq_n));
    end
  endfunction

  // Driver: offer queued events, predict each one on its transfer
  int in_gap, in_calm;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      in_gap = 0;
      in_calm = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        results_due.push_back(expander_step(in_ch.data));
        n_sent++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (events_pending.size() > 0) begin
        in_ch.data  <= events_pending.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = idle_len(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, stall at random, hold off long twice to back up the block
  int out_stall, out_calm, hold_left, holds_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      out_calm = 0;
      hold_left = 0;
      holds_done = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (hold_left == 0 && holds_done < 2 && n_checked >= 300 + 600 * holds_done) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = idle_len(out_calm);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("i2c_sixteen_bit_gpio_expander_unit verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Write the device address through the configuration port
  task automatic set_device_address(input logic [gpx_pkg::AddrW-1:0] a);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= gpx_pkg::CfgAddrW'(4 * gpx_pkg::REG_DEV_ADDR);
    cfg_pwdata  <= gpx_pkg::CfgDataW'(a);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    dev_addr = a;
    n_addrs++;
    @(negedge clk);
  endtask

  // Let every queued event go through and every result come back
  task automatic wait_idle();
    do @(negedge clk);
    while (events_pending.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    dev_addr  = gpx_pkg::DevAddrReset;
    pin_ext   = '0;
    chip_held = 1'b0;
    restore_defaults();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_device_address(gpx_pkg::DevAddrReset);
        1: set_device_address(7'h00);
        2: set_device_address(7'h7f);
        default: set_device_address(gpx_pkg::AddrW'($urandom));
      endcase
      if (ph == 0) queue_directed();
      while (events_pending.size() < PhaseEvents) queue_random_activity();
      wait_idle();
    end
    $display("sent %0d bus, pin and reset line events over %0d device addresses",
             n_sent, n_addrs);
    $display("compared %0d results, %0d mismatched", n_checked, n_bad);
    if (n_bad == 0 && results_due.size() == 0)
      $display("i2c_sixteen_bit_gpio_expander_unit verification clean");
    else
      $display("i2c_sixteen_bit_gpio_expander_unit verification failed");
    $finish;
  end

endmodule
